// ===== hw/rtl/epoch_seconds_to_calendar_macros.svh =====
// Assertion macros used by the calendar converter sequencer.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ECAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ECAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecal_pkg.sv =====
// Shared types, constants and the month-length function of the calendar converter.
package ecal_pkg;

  // Time constants, sized for the 32-bit seconds datapath
  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_PER_MINUTE = 32'd60;

  // Reciprocals for the odd parts of 86400, 3600 and 60 (675, 225, 15),
  // rounded up; exact over the operand range each one sees
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15

  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_COMMON_YR = 9'd365;
  localparam logic [11:0] FIRST_YEAR     = 12'd1970;

  // 1970 modulo 4, 100 and 400
  localparam logic [1:0] FIRST_MOD4   = 2'd2;
  localparam logic [6:0] FIRST_MOD100 = 7'd70;
  localparam logic [8:0] FIRST_MOD400 = 9'd370;
  localparam logic [6:0] MOD100_LAST  = 7'd99;
  localparam logic [8:0] MOD400_LAST  = 9'd399;

  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_DAY,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_FINISH
  } op_t;

  // rem_step: 0 = quotient step, 1 = remainder step of a split
  typedef struct packed {
    op_t  op;
    logic rem_step;
  } ecal_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } ecal_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_t;

  // Length of month m (0 = January), February by leap flag
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/ecal_ctrl.sv =====
// Sequencer for the calendar converter: steps the datapath through each phase.
`include "epoch_seconds_to_calendar_macros.svh"

module ecal_ctrl
  import ecal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ecal_cmd_t cmd,
  input  ecal_sts_t sts
);

  state_t     state_r, state_nxt;
  logic       step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       fin_fire;

  assign in_fire  = (state_r == ST_IDLE) && in_valid;
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Next state and split step: each split is a quotient step then a remainder step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DAY;
          step_nxt  = 1'b0;
        end
      end
      ST_DAY: begin
        if (step_r) begin
          state_nxt = ST_HOUR;
          step_nxt  = 1'b0;
        end else begin
          step_nxt = 1'b1;
        end
      end
      ST_HOUR: begin
        if (step_r) begin
          state_nxt = ST_MIN;
          step_nxt  = 1'b0;
        end else begin
          step_nxt = 1'b1;
        end
      end
      ST_MIN: begin
        if (step_r) begin
          state_nxt = ST_YEAR;
          step_nxt  = 1'b0;
        end else begin
          step_nxt = 1'b1;
        end
      end
      ST_YEAR: begin
        if (sts.year_done) state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        if (sts.month_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath command for the current state
  always_comb begin
    cmd.rem_step = step_r;
    unique case (state_r)
      ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      ST_DAY:   cmd.op = OP_DIV_DAY;
      ST_HOUR:  cmd.op = OP_DIV_HOUR;
      ST_MIN:   cmd.op = OP_DIV_MIN;
      ST_YEAR:  cmd.op = OP_YEAR;
      ST_MONTH: cmd.op = OP_MONTH;
      ST_FIN:   cmd.op = fin_fire ? OP_FINISH : OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  // Result valid: set when the output register loads, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `ECAL_ASSERT_NEXT(a_load_starts_day, in_fire, (state_r == ST_DAY) && !step_r, "day split not started")
  `ECAL_ASSERT_NEXT(a_finish_sets_valid, fin_fire, out_valid_r, "result loaded without valid")
  `ECAL_ASSERT_NEXT(a_year_to_month, (state_r == ST_YEAR) && sts.year_done, state_r == ST_MONTH, "year strip finished but month strip not entered")
  `ECAL_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, cmd.op != OP_FINISH, "pending result overwritten")

endmodule

// ===== hw/rtl/ecal_dp.sv =====
// Datapath of the calendar converter: reciprocal-multiply time split, year and month strip.
module ecal_dp
  import ecal_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] in_epoch_seconds,
  input  ecal_cmd_t   cmd,
  output ecal_sts_t   sts,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds_of_minute
);

  logic [31:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hours_r, hours_nxt;
  logic [5:0]  minutes_r, minutes_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  mod4_r, mod4_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [8:0]  mod400_r, mod400_nxt;
  logic [3:0]  mon_r, mon_nxt;

  logic [11:0] oyear_r;
  logic [3:0]  omonth_r;
  logic [4:0]  oday_r;
  logic [4:0]  ohours_r;
  logic [5:0]  ominutes_r;
  logic [5:0]  oseconds_r;

  logic [50:0] day_mul;
  logic [26:0] hour_mul;
  logic [20:0] min_mul;
  logic [31:0] day_secs;
  logic [31:0] hour_secs;
  logic [31:0] min_secs;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // Quotients: drop the power-of-two factor, then multiply by the reciprocal
  assign day_mul  = rem_r[31:7] * DAY_RECIP;   // secs / 128 / 675
  assign hour_mul = rem_r[16:4] * HOUR_RECIP;  // tod / 16 / 225, tod < 86400
  assign min_mul  = rem_r[11:2] * MIN_RECIP;   // rest / 4 / 15, rest < 3600

  // Seconds covered by each quotient, taken off the remainder
  assign day_secs  = {16'd0, days_r} * SECS_PER_DAY;
  assign hour_secs = {27'd0, hours_r} * SECS_PER_HOUR;
  assign min_secs  = {26'd0, minutes_r} * SECS_PER_MINUTE;

  // Gregorian leap rule from running residues of the year
  assign leap = ((mod4_r == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);
  assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YR;
  assign mlen = month_days(mon_r, leap);

  assign sts.year_done  = (days_r < {7'd0, ylen});
  assign sts.month_done = (mon_r == MONTH_LAST) || (days_r < {11'd0, mlen});

  // Next values per operation
  always_comb begin
    rem_nxt     = rem_r;
    days_nxt    = days_r;
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    year_nxt    = year_r;
    mod4_nxt    = mod4_r;
    mod100_nxt  = mod100_r;
    mod400_nxt  = mod400_r;
    mon_nxt     = mon_r;
    case (cmd.op)
      OP_LOAD: begin
        rem_nxt     = in_epoch_seconds;
        days_nxt    = 16'd0;
        hours_nxt   = 5'd0;
        minutes_nxt = 6'd0;
        year_nxt    = FIRST_YEAR;
        mod4_nxt    = FIRST_MOD4;
        mod100_nxt  = FIRST_MOD100;
        mod400_nxt  = FIRST_MOD400;
        mon_nxt     = 4'd0;
      end
      OP_DIV_DAY: begin
        if (cmd.rem_step) begin
          rem_nxt = rem_r - day_secs;
        end else begin
          days_nxt = day_mul[50:35];
        end
      end
      OP_DIV_HOUR: begin
        if (cmd.rem_step) begin
          rem_nxt = rem_r - hour_secs;
        end else begin
          hours_nxt = hour_mul[25:21];
        end
      end
      OP_DIV_MIN: begin
        if (cmd.rem_step) begin
          rem_nxt = rem_r - min_secs;
        end else begin
          minutes_nxt = min_mul[19:14];
        end
      end
      OP_YEAR: begin
        if (!sts.year_done) begin
          days_nxt   = days_r - {7'd0, ylen};
          year_nxt   = year_r + 12'd1;
          mod4_nxt   = mod4_r + 2'd1;
          mod100_nxt = (mod100_r == MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
          mod400_nxt = (mod400_r == MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
        end
      end
      OP_MONTH: begin
        if (!sts.month_done) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    days_r    <= days_nxt;
    hours_r   <= hours_nxt;
    minutes_r <= minutes_nxt;
    year_r    <= year_nxt;
    mod4_r    <= mod4_nxt;
    mod100_r  <= mod100_nxt;
    mod400_r  <= mod400_nxt;
    mon_r     <= mon_nxt;
  end

  // Output register, loaded when the result is handed over
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      oyear_r    <= year_r;
      omonth_r   <= mon_r + 4'd1;
      oday_r     <= days_r[4:0] + 5'd1;
      ohours_r   <= hours_r;
      ominutes_r <= minutes_r;
      oseconds_r <= rem_r[5:0];
    end
  end

  assign out_year              = oyear_r;
  assign out_month             = omonth_r;
  assign out_day_of_month      = oday_r;
  assign out_hours             = ohours_r;
  assign out_minutes           = ominutes_r;
  assign out_seconds_of_minute = oseconds_r;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Top level of the seconds-since-1970 to Gregorian date and time converter.
//
// Input channel: in_epoch_seconds with in_valid / in_ready. One request is a
// 32-bit unsigned count of seconds since 1970-01-01 00:00:00.
// Result channel: out_year, out_month, out_day_of_month, out_hours,
// out_minutes, out_seconds_of_minute with out_valid / out_ready.
// One request gives exactly one result, in order.
// Flow: the day, hour and minute split, then the year strip over the whole
// years after 1970, then the month strip over the whole months into the
// final year, then out_valid. The year strip, one year per cycle, dominates;
// the day, hour and minute split is a reciprocal multiply and a multiply-back
// subtract for each field.
// One request is in work at a time; in_ready is high only while idle, so a
// new request is taken only after the previous conversion has finished.
// The result sits in an output register, so a new request is accepted and
// converted while the previous result waits; if that result is still not
// taken when the next one is done, the converter holds until out_ready.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module epoch_seconds_to_calendar
  import ecal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds_of_minute
);

  ecal_cmd_t cmd;
  ecal_sts_t sts;

  // Sequencer
  ecal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and result register
  ecal_dp u_dp (
    .clk                   (clk),
    .in_epoch_seconds      (in_epoch_seconds),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_year              (out_year),
    .out_month             (out_month),
    .out_day_of_month      (out_day_of_month),
    .out_hours             (out_hours),
    .out_minutes           (out_minutes),
    .out_seconds_of_minute (out_seconds_of_minute)
  );

endmodule
